// ===== rtl/core/spsu_pkg.sv =====
`timescale 1ns / 1ps

package spsu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CELL_N  = 8;
    localparam int unsigned WIN_W   = (CELL_N + 1) * BYTE_W;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              is_last;
    } spsu_in_t;

    typedef struct packed {
        logic hit_secret;
        logic hit_eval;
        logic hit_exec;
        logic hit_shell_true;
        logic hit_sql_concat;
        logic hit_innerhtml;
    } spsu_out_t;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/spsu_cell.sv =====
`timescale 1ns / 1ps

module spsu_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift,
    input  logic                       clear,
    input  logic [spsu_pkg::BYTE_W-1:0] d_in,
    output logic [spsu_pkg::BYTE_W-1:0] d_out
);
    import spsu_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = '0;
        end else if (shift) begin
            byte_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign d_out = byte_reg;

endmodule

// ===== rtl/core/spsu_detect.sv =====
`timescale 1ns / 1ps

module spsu_detect (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        last,
    input  logic [spsu_pkg::BYTE_W-1:0] raw_byte,
    input  logic [spsu_pkg::WIN_W-1:0]  win,
    output spsu_pkg::spsu_out_t         flags_next
);
    import spsu_pkg::*;

    localparam logic [63:0] KW_PASSWORD  = "password";
    localparam logic [47:0] KW_PASSWD    = "passwd";
    localparam logic [47:0] KW_SECRET    = "secret";
    localparam logic [55:0] KW_API_KEY   = "api_key";
    localparam logic [47:0] KW_APIKEY    = "apikey";
    localparam logic [31:0] KW_EVAL      = "eval";
    localparam logic [31:0] KW_EXEC      = "exec";
    localparam logic [39:0] KW_SHELL     = "shell";
    localparam logic [47:0] KW_SELECT    = "select";
    localparam logic [31:0] KW_FROM      = "from";
    localparam logic [71:0] KW_INNERHTML = "innerhtml";

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CH_LOW_E  = 8'h65;
    localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIG_9  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;

    typedef enum logic [2:0] {
        Q_NONE = 3'b001,
        Q_OPEN = 3'b010,
        Q_FULL = 3'b100
    } quote_state_t;

    typedef enum logic [2:0] {
        SEC_IDLE = 3'b001,
        SEC_KEY  = 3'b010,
        SEC_EQ   = 3'b100
    } sec_state_t;

    typedef enum logic [6:0] {
        SH_IDLE = 7'b0000001,
        SH_KEY  = 7'b0000010,
        SH_EQ   = 7'b0000100,
        SH_T    = 7'b0001000,
        SH_TR   = 7'b0010000,
        SH_TRU  = 7'b0100000,
        SH_TRUE = 7'b1000000
    } shell_state_t;

    typedef enum logic [3:0] {
        SQL_IDLE = 4'b0001,
        SQL_SEL  = 4'b0010,
        SQL_PLUS = 4'b0100,
        SQL_DONE = 4'b1000
    } sql_state_t;

    quote_state_t dq_reg, dq_next;
    quote_state_t sq_reg, sq_next;
    sec_state_t   sec_reg, sec_next;
    shell_state_t sh_reg, sh_next;
    sql_state_t   sql_reg, sql_next;
    logic         eval_wait_reg, eval_wait_next;
    logic         exec_wait_reg, exec_wait_next;
    logic         html_wait_reg, html_wait_next;
    spsu_out_t    hit_reg, hit_next;

    logic [BYTE_W-1:0] lc;
    logic ws;
    logic alnum;
    logic kw_secret, kw_eval, kw_exec, kw_shell, kw_select, kw_from, kw_html;

    assign lc    = win[BYTE_W-1:0];
    assign ws    = (raw_byte == CH_SPACE) || (raw_byte == CH_TAB) || (raw_byte == CH_CR) ||
                   (raw_byte >= CH_LF && raw_byte <= CH_FF);
    assign alnum = (lc >= CH_DIG_0 && lc <= CH_DIG_9) || (lc >= CH_LOW_A && lc <= CH_LOW_Z);

    assign kw_secret = (win[63:0] == KW_PASSWORD) || (win[47:0] == KW_PASSWD) ||
                       (win[47:0] == KW_SECRET) || (win[55:0] == KW_API_KEY) ||
                       (win[47:0] == KW_APIKEY);
    assign kw_eval   = (win[31:0] == KW_EVAL);
    assign kw_exec   = (win[31:0] == KW_EXEC);
    assign kw_shell  = (win[39:0] == KW_SHELL);
    assign kw_select = (win[47:0] == KW_SELECT);
    assign kw_from   = (win[31:0] == KW_FROM);
    assign kw_html   = (win[71:0] == KW_INNERHTML);

    always_comb begin
        hit_next       = hit_reg;
        dq_next        = dq_reg;
        sq_next        = sq_reg;
        sec_next       = sec_reg;
        sh_next        = sh_reg;
        sql_next       = sql_reg;
        eval_wait_next = eval_wait_reg;
        exec_wait_next = exec_wait_reg;
        html_wait_next = html_wait_reg;

        // a quote first closes any pending opening of its own kind
        if (raw_byte == CH_DQUOTE) begin
            if (dq_reg == Q_FULL) hit_next.hit_secret = 1'b1;
            dq_next = Q_NONE;
        end else if (dq_reg == Q_OPEN) begin
            dq_next = Q_FULL;
        end
        if (raw_byte == CH_SQUOTE) begin
            if (sq_reg == Q_FULL) hit_next.hit_secret = 1'b1;
            sq_next = Q_NONE;
        end else if (sq_reg == Q_OPEN) begin
            sq_next = Q_FULL;
        end

        if (kw_secret) begin
            sec_next = SEC_KEY;
        end else begin
            case (sec_reg)
                SEC_KEY: begin
                    if (ws) sec_next = SEC_KEY;
                    else if (raw_byte == CH_EQUALS) sec_next = SEC_EQ;
                    else sec_next = SEC_IDLE;
                end
                SEC_EQ: begin
                    if (!ws) begin
                        if (raw_byte == CH_DQUOTE) dq_next = Q_OPEN;
                        else if (raw_byte == CH_SQUOTE) sq_next = Q_OPEN;
                        sec_next = SEC_IDLE;
                    end
                end
                default: sec_next = SEC_IDLE;
            endcase
        end

        if (kw_eval) begin
            eval_wait_next = 1'b1;
        end else if (eval_wait_reg && !ws) begin
            if (raw_byte == CH_LPAREN) hit_next.hit_eval = 1'b1;
            eval_wait_next = 1'b0;
        end
        if (kw_exec) begin
            exec_wait_next = 1'b1;
        end else if (exec_wait_reg && !ws) begin
            if (raw_byte == CH_LPAREN) hit_next.hit_exec = 1'b1;
            exec_wait_next = 1'b0;
        end
        if (kw_html) begin
            html_wait_next = 1'b1;
        end else if (html_wait_reg && !ws) begin
            if (raw_byte == CH_EQUALS) hit_next.hit_innerhtml = 1'b1;
            html_wait_next = 1'b0;
        end

        if (kw_shell) begin
            sh_next = SH_KEY;
        end else begin
            case (sh_reg)
                SH_KEY: begin
                    if (ws) sh_next = SH_KEY;
                    else if (raw_byte == CH_EQUALS) sh_next = SH_EQ;
                    else sh_next = SH_IDLE;
                end
                SH_EQ: begin
                    if (ws) sh_next = SH_EQ;
                    else if (lc == CH_LOW_T) sh_next = SH_T;
                    else sh_next = SH_IDLE;
                end
                SH_T:    sh_next = (lc == CH_LOW_R) ? SH_TR : SH_IDLE;
                SH_TR:   sh_next = (lc == CH_LOW_U) ? SH_TRU : SH_IDLE;
                SH_TRU:  sh_next = (lc == CH_LOW_E) ? SH_TRUE : SH_IDLE;
                SH_TRUE: begin
                    if (!alnum) hit_next.hit_shell_true = 1'b1;
                    sh_next = SH_IDLE;
                end
                default: sh_next = SH_IDLE;
            endcase
        end
        if (last && sh_next == SH_TRUE) hit_next.hit_shell_true = 1'b1;

        case (sql_reg)
            SQL_IDLE: if (kw_select) sql_next = SQL_SEL;
            SQL_SEL:  if (raw_byte == CH_PLUS) sql_next = SQL_PLUS;
            SQL_PLUS: begin
                if (kw_from) begin
                    hit_next.hit_sql_concat = 1'b1;
                    sql_next = SQL_DONE;
                end
            end
            SQL_DONE: sql_next = SQL_DONE;
            default:  sql_next = SQL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (en && last)) begin
            dq_reg        <= Q_NONE;
            sq_reg        <= Q_NONE;
            sec_reg       <= SEC_IDLE;
            sh_reg        <= SH_IDLE;
            sql_reg       <= SQL_IDLE;
            eval_wait_reg <= 1'b0;
            exec_wait_reg <= 1'b0;
            html_wait_reg <= 1'b0;
            hit_reg       <= '0;
        end else if (en) begin
            dq_reg        <= dq_next;
            sq_reg        <= sq_next;
            sec_reg       <= sec_next;
            sh_reg        <= sh_next;
            sql_reg       <= sql_next;
            eval_wait_reg <= eval_wait_next;
            exec_wait_reg <= exec_wait_next;
            html_wait_reg <= html_wait_next;
            hit_reg       <= hit_next;
        end
    end

    assign flags_next = hit_next;

endmodule

// ===== rtl/core/security_pattern_scanner_unit.sv =====
`timescale 1ns / 1ps

// Streaming scanner for six insecure source code patterns.
// Input channel s_*: one text byte per transaction, is_last marks the final
// byte of a text. Result channel m_*: one transaction per text, carrying six
// sticky hit flags, issued after the byte marked last.
// The byte window is a row of eight byte cells shifting once per accepted
// byte; keyword compares and detector phases settle in that same cycle.
// Throughput: one byte per cycle while s_ready is high. The result of a text is
// registered into the output register, or into the skid register if that is held.
// Results go through an output register backed by one skid register, so
// bytes keep flowing while a result waits. s_ready drops only when both
// hold a result that the receiver has not taken.
// Reset (aresetn low, synchronous) clears the window, all detector phases,
// the flags and the valid bits of both result registers. Each last byte also
// returns the window and the detector to their reset state for the next text.

module security_pattern_scanner_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spsu_pkg::spsu_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output spsu_pkg::spsu_out_t m_payload
);
    import spsu_pkg::*;

    logic              s_fire;
    logic              res_fire;
    logic [BYTE_W-1:0] lc;
    logic [BYTE_W-1:0] cell_q [CELL_N];
    logic [WIN_W-1:0]  win;
    spsu_out_t         flags_next;

    logic      out_valid_reg, out_valid_next;
    spsu_out_t out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    spsu_out_t skid_data_reg, skid_data_next;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign res_fire = s_fire && s_payload.is_last;
    assign lc       = to_lower(s_payload.text_byte);

    genvar k;
    generate
        for (k = 0; k < CELL_N; k++) begin : g_cell
            logic [BYTE_W-1:0] d_in;
            if (k == CELL_N - 1) begin : g_head
                assign d_in = lc;
            end else begin : g_body
                assign d_in = cell_q[k+1];
            end
            spsu_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (s_fire),
                .clear   (res_fire),
                .d_in    (d_in),
                .d_out   (cell_q[k])
            );
            assign win[WIN_W-1-k*BYTE_W -: BYTE_W] = cell_q[k];
        end
    endgenerate
    assign win[BYTE_W-1:0] = lc;

    spsu_detect u_detect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (s_fire),
        .last       (s_payload.is_last),
        .raw_byte   (s_payload.text_byte),
        .win        (win),
        .flags_next (flags_next)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_fire) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = flags_next;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = flags_next;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> out_valid_reg)
        else $error("last byte accepted but no result presented");

    a_window_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> (win[WIN_W-1:BYTE_W] == '0))
        else $error("byte window not cleared after end of text");

endmodule
